// ===== rtl/core/pkee_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkee_pkg
// Shared types and constants for the panel key and knob event decoder.
// ----------------------------------------------------------------------------
package pkee_pkg;

	// number of keys; key codes run from 1 to NUM_KEYS-1
	localparam int NUM_KEYS = 19;

	// field widths
	localparam int CMD_W   = 8;
	localparam int TIME_W  = 32;
	localparam int DEB_W   = 16;
	localparam int KEY_W   = 5;
	localparam int KNOB_W  = 6;
	localparam int STEP_W  = 8;
	localparam int KIND_W  = 3;
	localparam int CODE_W  = 6;
	localparam int WIDX_W  = 2;
	localparam int WDATA_W = 16;

	// command byte ranges
	localparam logic [CMD_W-1:0] PRESS_BIT   = 8'h80;
	localparam logic [CMD_W-1:0] LOW7        = 8'h7f;
	localparam logic [CMD_W-1:0] KEY_LIMIT   = 8'(NUM_KEYS);
	localparam logic [CMD_W-1:0] PRESS_LIMIT = 8'(NUM_KEYS) | PRESS_BIT;
	localparam logic [CMD_W-1:0] TURN_LO     = 8'd20;
	localparam logic [CMD_W-1:0] TURN_HI     = 8'd27;
	localparam logic [CMD_W-1:0] KNOB_LO     = 8'h1c;
	localparam logic [CMD_W-1:0] KNOB_HI     = 8'h23;
	localparam logic [STEP_W-1:0] STEP_MAX   = 8'hff;

	// configuration reset values
	localparam logic              RUNNING_RST  = 1'b1;
	localparam logic [DEB_W-1:0]  DEBOUNCE_RST = 16'd100;
	localparam logic [CMD_W-1:0]  RST_CODE_RST = 8'hff;

	// configuration register indexes
	localparam logic [WIDX_W-1:0] REG_RUNNING    = 2'd0;
	localparam logic [WIDX_W-1:0] REG_DEBOUNCE   = 2'd1;
	localparam logic [WIDX_W-1:0] REG_RESET_CODE = 2'd2;

	// request kinds
	localparam logic KIND_COMMAND = 1'b0;
	localparam logic KIND_SERVICE = 1'b1;

	// reported event kinds
	typedef enum logic [KIND_W-1:0] {
		EV_NONE         = 3'd0,
		EV_KEY_RELEASE  = 3'd1,
		EV_KEY_PRESS    = 3'd2,
		EV_TURN_LEFT    = 3'd3,
		EV_TURN_RIGHT   = 3'd4,
		EV_KNOB_PRESS   = 3'd5,
		EV_KNOB_RELEASE = 3'd6,
		EV_RESET        = 3'd7
	} event_kind_t;

endpackage

// ===== rtl/core/pkee_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkee_in_if
// Request channel into the panel decoder: command byte or service tick.
// ----------------------------------------------------------------------------
interface pkee_in_if;
	logic                         valid;
	logic                         ready;
	logic                         kind;
	logic [pkee_pkg::CMD_W-1:0]   command_byte;
	logic [pkee_pkg::TIME_W-1:0]  time_ms;

	modport source (output valid, kind, command_byte, time_ms, input ready);
	modport sink   (input valid, kind, command_byte, time_ms, output ready);
endinterface

// ===== rtl/core/pkee_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkee_out_if
// Result channel out of the panel decoder.
// ----------------------------------------------------------------------------
interface pkee_out_if;
	logic                         valid;
	logic                         ready;
	logic                         accepted;
	logic [pkee_pkg::KIND_W-1:0]  event_kind;
	logic [pkee_pkg::CODE_W-1:0]  event_code;
	logic [pkee_pkg::STEP_W-1:0]  turn_steps;
	logic [pkee_pkg::KEY_W-1:0]   captured_key;

	modport source (output valid, accepted, event_kind, event_code, turn_steps,
		captured_key, input ready);
	modport sink   (input valid, accepted, event_kind, event_code, turn_steps,
		captured_key, output ready);
endinterface

// ===== rtl/core/panel_key_encoder_event_latch.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// panel_key_encoder_event_latch
// Front-panel command decoder with debounced key latches and knob events.
// ----------------------------------------------------------------------------
// One request per clock while the output is not stalled: a request is taken
// into the input register, decoded there against the event latches, and its
// result is written into the output register when the result stage can
// advance. The limit is the single read-modify-write of the latch state done
// in the decode stage; back-to-back requests see each other's updates without
// bubbles. A stalled output holds both stages in place.
// Configuration writes take effect at once and should only be made while no
// request is in flight.
module panel_key_encoder_event_latch (
	input  logic                          clk,
	input  logic                          arst_n,
	pkee_in_if.sink                       in_ch,
	pkee_out_if.source                    out_ch,
	input  logic                          wr_en,
	input  logic [pkee_pkg::WIDX_W-1:0]   wr_index,
	input  logic [pkee_pkg::WDATA_W-1:0]  wr_data
);

	// configuration
	logic                          running_q;
	logic [pkee_pkg::DEB_W-1:0]    debounce_q;
	logic [pkee_pkg::CMD_W-1:0]    reset_code_q;

	// event state
	logic [pkee_pkg::TIME_W-1:0]   last_release_q, last_press_q;
	logic [pkee_pkg::KEY_W-1:0]    release_latch_q, press_latch_q;
	logic [pkee_pkg::KNOB_W-1:0]   left_latch_q, right_latch_q;
	logic [pkee_pkg::KNOB_W-1:0]   knob_press_q, knob_release_q;
	logic [pkee_pkg::STEP_W-1:0]   step_count_q;
	logic                          reset_pending_q;

	// input stage
	logic                          valid_s1;
	logic                          kind_s1;
	logic [pkee_pkg::CMD_W-1:0]    cmd_s1;
	logic [pkee_pkg::TIME_W-1:0]   time_s1;

	// result stage
	logic                          valid_s2;
	logic                          accepted_s2;
	logic [pkee_pkg::KIND_W-1:0]   event_kind_s2;
	logic [pkee_pkg::CODE_W-1:0]   event_code_s2;
	logic [pkee_pkg::STEP_W-1:0]   turn_steps_s2;
	logic [pkee_pkg::KEY_W-1:0]    captured_s2;

	logic adv;
	logic fire;

	// pipeline flow control
	assign adv         = !valid_s2 || out_ch.ready;
	assign fire        = valid_s1 && adv;
	assign in_ch.ready = !valid_s1 || adv;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q    <= pkee_pkg::RUNNING_RST;
			debounce_q   <= pkee_pkg::DEBOUNCE_RST;
			reset_code_q <= pkee_pkg::RST_CODE_RST;
		end else if (wr_en) begin
			case (wr_index)
				pkee_pkg::REG_RUNNING:    running_q    <= wr_data[0];
				pkee_pkg::REG_DEBOUNCE:   debounce_q   <= wr_data[pkee_pkg::DEB_W-1:0];
				pkee_pkg::REG_RESET_CODE: reset_code_q <= wr_data[pkee_pkg::CMD_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			kind_s1 <= in_ch.kind;
			cmd_s1  <= in_ch.command_byte;
			time_s1 <= in_ch.time_ms;
		end
	end

	// debounce checks
	logic [pkee_pkg::TIME_W-1:0] release_age, press_age;
	logic is_release, is_press, release_hit, press_hit;
	logic is_left, is_right, is_knob_press, is_knob_release;

	assign release_age = time_s1 - last_release_q;
	assign press_age   = time_s1 - last_press_q;
	assign is_release  = (cmd_s1 != '0) && (cmd_s1 < pkee_pkg::KEY_LIMIT);
	assign is_press    = (cmd_s1 > pkee_pkg::PRESS_BIT) && (cmd_s1 < pkee_pkg::PRESS_LIMIT);
	assign release_hit = is_release
		&& (release_age > {{(pkee_pkg::TIME_W-pkee_pkg::DEB_W){1'b0}}, debounce_q});
	assign press_hit   = is_press
		&& (press_age > {{(pkee_pkg::TIME_W-pkee_pkg::DEB_W){1'b0}}, debounce_q});

	// class ranges
	assign is_left         = (cmd_s1 >= pkee_pkg::TURN_LO) && (cmd_s1 <= pkee_pkg::TURN_HI);
	assign is_right        = (cmd_s1 >= (pkee_pkg::TURN_LO | pkee_pkg::PRESS_BIT))
		&& (cmd_s1 <= (pkee_pkg::TURN_HI | pkee_pkg::PRESS_BIT));
	assign is_knob_press   = (cmd_s1 >= (pkee_pkg::KNOB_LO | pkee_pkg::PRESS_BIT))
		&& (cmd_s1 <= (pkee_pkg::KNOB_HI | pkee_pkg::PRESS_BIT));
	assign is_knob_release = (cmd_s1 >= pkee_pkg::KNOB_LO) && (cmd_s1 <= pkee_pkg::KNOB_HI);

	// next state and result
	logic [pkee_pkg::TIME_W-1:0]  last_release_d, last_press_d;
	logic [pkee_pkg::KEY_W-1:0]   release_latch_d, press_latch_d;
	logic [pkee_pkg::KNOB_W-1:0]  left_latch_d, right_latch_d;
	logic [pkee_pkg::KNOB_W-1:0]  knob_press_d, knob_release_d;
	logic [pkee_pkg::STEP_W-1:0]  step_count_d, step_inc;
	logic                         reset_pending_d;
	logic                         accepted_d;
	pkee_pkg::event_kind_t        event_kind_d;
	logic [pkee_pkg::CODE_W-1:0]  event_code_d;
	logic [pkee_pkg::STEP_W-1:0]  turn_steps_d;
	logic [pkee_pkg::KEY_W-1:0]   captured_d;

	assign step_inc = (step_count_q == pkee_pkg::STEP_MAX) ? step_count_q
		: step_count_q + 1'b1;

	always_comb begin
		last_release_d  = last_release_q;
		last_press_d    = last_press_q;
		release_latch_d = release_latch_q;
		press_latch_d   = press_latch_q;
		left_latch_d    = left_latch_q;
		right_latch_d   = right_latch_q;
		knob_press_d    = knob_press_q;
		knob_release_d  = knob_release_q;
		step_count_d    = step_count_q;
		reset_pending_d = reset_pending_q;
		accepted_d      = 1'b1;
		event_kind_d    = pkee_pkg::EV_NONE;
		event_code_d    = '0;
		turn_steps_d    = '0;
		captured_d      = '0;

		if (kind_s1 == pkee_pkg::KIND_COMMAND) begin
			// command byte decode; a zero byte is ignored
			if (cmd_s1 != '0) begin
				if (!running_q) begin
					if (release_hit) begin
						last_release_d = time_s1;
						captured_d     = cmd_s1[pkee_pkg::KEY_W-1:0];
					end
				end else if (release_hit) begin
					last_release_d  = time_s1;
					release_latch_d = cmd_s1[pkee_pkg::KEY_W-1:0];
				end else if (press_hit) begin
					last_press_d  = time_s1;
					press_latch_d = cmd_s1[pkee_pkg::KEY_W-1:0];
				end else if (is_left) begin
					left_latch_d = cmd_s1[pkee_pkg::KNOB_W-1:0];
					step_count_d = step_inc;
				end else if (is_right) begin
					right_latch_d = cmd_s1[pkee_pkg::KNOB_W-1:0];
					step_count_d  = step_inc;
				end else if (is_knob_press) begin
					knob_press_d = cmd_s1[pkee_pkg::KNOB_W-1:0];
				end else if (is_knob_release) begin
					knob_release_d = cmd_s1[pkee_pkg::KNOB_W-1:0];
				end else if (cmd_s1 == reset_code_q) begin
					reset_pending_d = 1'b1;
				end else begin
					accepted_d = 1'b0;
				end
			end
		end else begin
			// service tick: report highest-priority latched event
			if (running_q) begin
				if (release_latch_q != '0) begin
					event_kind_d = pkee_pkg::EV_KEY_RELEASE;
					event_code_d = pkee_pkg::CODE_W'(release_latch_q);
				end else if (press_latch_q != '0) begin
					event_kind_d = pkee_pkg::EV_KEY_PRESS;
					event_code_d = pkee_pkg::CODE_W'(press_latch_q);
				end else if (left_latch_q != '0) begin
					event_kind_d = pkee_pkg::EV_TURN_LEFT;
					event_code_d = left_latch_q;
					turn_steps_d = step_count_q;
				end else if (right_latch_q != '0) begin
					event_kind_d = pkee_pkg::EV_TURN_RIGHT;
					event_code_d = right_latch_q;
					turn_steps_d = step_count_q;
				end else if (knob_press_q != '0) begin
					event_kind_d = pkee_pkg::EV_KNOB_PRESS;
					event_code_d = knob_press_q;
					knob_press_d = '0;
				end else if (knob_release_q != '0) begin
					event_kind_d   = pkee_pkg::EV_KNOB_RELEASE;
					event_code_d   = knob_release_q;
					knob_release_d = '0;
				end else if (reset_pending_q) begin
					event_kind_d    = pkee_pkg::EV_RESET;
					reset_pending_d = 1'b0;
				end
			end
			release_latch_d = '0;
			press_latch_d   = '0;
			left_latch_d    = '0;
			right_latch_d   = '0;
			step_count_d    = '0;
		end
	end

	// event state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_release_q  <= '0;
			last_press_q    <= '0;
			release_latch_q <= '0;
			press_latch_q   <= '0;
			left_latch_q    <= '0;
			right_latch_q   <= '0;
			knob_press_q    <= '0;
			knob_release_q  <= '0;
			step_count_q    <= '0;
			reset_pending_q <= 1'b0;
		end else if (fire) begin
			last_release_q  <= last_release_d;
			last_press_q    <= last_press_d;
			release_latch_q <= release_latch_d;
			press_latch_q   <= press_latch_d;
			left_latch_q    <= left_latch_d;
			right_latch_q   <= right_latch_d;
			knob_press_q    <= knob_press_d;
			knob_release_q  <= knob_release_d;
			step_count_q    <= step_count_d;
			reset_pending_q <= reset_pending_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			accepted_s2   <= accepted_d;
			event_kind_s2 <= event_kind_d;
			event_code_s2 <= event_code_d;
			turn_steps_s2 <= turn_steps_d;
			captured_s2   <= captured_d;
		end
	end

	assign out_ch.valid        = valid_s2;
	assign out_ch.accepted     = accepted_s2;
	assign out_ch.event_kind   = event_kind_s2;
	assign out_ch.event_code   = event_code_s2;
	assign out_ch.turn_steps   = turn_steps_s2;
	assign out_ch.captured_key = captured_s2;

	// reported events are always accepted and never carry a captured key
	a_event_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && event_kind_s2 != pkee_pkg::EV_NONE)
			|-> (accepted_s2 && captured_s2 == '0))
		else $error("reported event with accepted low or captured key set");

	// a service request empties the key and turn latches
	a_service_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && kind_s1 == pkee_pkg::KIND_SERVICE)
			|=> (step_count_q == '0 && release_latch_q == '0 && left_latch_q == '0))
		else $error("latches not cleared after service request");

	// a stalled request keeps its slot in the input stage
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> (valid_s1 && $stable(time_s1) && $stable(cmd_s1)))
		else $error("input stage lost a stalled request");

	// turn steps appear only on turn events
	a_steps_turn_only: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && turn_steps_s2 != '0) |->
			(event_kind_s2 == pkee_pkg::EV_TURN_LEFT
				|| event_kind_s2 == pkee_pkg::EV_TURN_RIGHT))
		else $error("turn steps reported on a non-turn event");

endmodule

// ===== tb/panel_key_encoder_event_latch_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// panel_key_encoder_event_latch_checker
// Watches the request and result channels and the register port of the panel
// decoder. It keeps its own copy of the latch state and settings, works out
// the result of every accepted request, and compares each accepted result
// field by field against the oldest one still waiting.
// ----------------------------------------------------------------------------
module panel_key_encoder_event_latch_checker
	import pkee_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	pkee_in_if                  in_ch,
	pkee_out_if                 out_ch,
	input  logic                wr_en,
	input  logic [WIDX_W-1:0]   wr_index,
	input  logic [WDATA_W-1:0]  wr_data,
	output int                  fail_count,
	output int                  outstanding
);

	typedef struct packed {
		logic               accepted;
		event_kind_t        ev;
		logic [CODE_W-1:0]  code;
		logic [STEP_W-1:0]  steps;
		logic [KEY_W-1:0]   captured;
	} panel_result_t;

	// settings
	logic               run_en;
	logic [DEB_W-1:0]   debounce;
	logic [CMD_W-1:0]   rst_code;

	// debounce stamps and event latches
	logic [TIME_W-1:0]  release_stamp;
	logic [TIME_W-1:0]  press_stamp;
	logic [KEY_W-1:0]   rel_key;
	logic [KEY_W-1:0]   press_key;
	logic [KNOB_W-1:0]  left_knob;
	logic [KNOB_W-1:0]  right_knob;
	logic [KNOB_W-1:0]  knob_down;
	logic [KNOB_W-1:0]  knob_up;
	logic [STEP_W-1:0]  step_total;
	logic               reset_req;

	panel_result_t      pending_results[$];

	// debounced key release; stamps the time when it passes
	function automatic logic release_ok(logic [CMD_W-1:0] cmd, logic [TIME_W-1:0] now);
		if (cmd != '0 && cmd < KEY_LIMIT && (now - release_stamp) > TIME_W'(debounce)) begin
			release_stamp = now;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// debounced key press
	function automatic logic press_ok(logic [CMD_W-1:0] cmd, logic [TIME_W-1:0] now);
		if (cmd > PRESS_BIT && cmd < PRESS_LIMIT && (now - press_stamp) > TIME_W'(debounce))
		begin
			press_stamp = now;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// decode one request against the latches and return its result
	function automatic panel_result_t decode_request(logic kind, logic [CMD_W-1:0] cmd,
		logic [TIME_W-1:0] now);
		panel_result_t r;
		r = '{1'b1, EV_NONE, '0, '0, '0};
		if (kind == KIND_COMMAND) begin
			if (cmd != '0) begin
				if (!run_en) begin
					if (release_ok(cmd, now))
						r.captured = KEY_W'(cmd);
				end else if (release_ok(cmd, now)) begin
					rel_key = KEY_W'(cmd);
				end else if (press_ok(cmd, now)) begin
					press_key = KEY_W'(cmd & LOW7);
				end else if (cmd >= TURN_LO && cmd <= TURN_HI) begin
					left_knob = KNOB_W'(cmd);
					if (step_total != STEP_MAX)
						step_total++;
				end else if (cmd >= (TURN_LO | PRESS_BIT) && cmd <= (TURN_HI | PRESS_BIT)) begin
					right_knob = KNOB_W'(cmd & LOW7);
					if (step_total != STEP_MAX)
						step_total++;
				end else if (cmd >= (KNOB_LO | PRESS_BIT) && cmd <= (KNOB_HI | PRESS_BIT)) begin
					knob_down = KNOB_W'(cmd & LOW7);
				end else if (cmd >= KNOB_LO && cmd <= KNOB_HI) begin
					knob_up = KNOB_W'(cmd);
				end else if (cmd == rst_code) begin
					reset_req = 1'b1;
				end else begin
					r.accepted = 1'b0;
				end
			end
		end else begin
			// service: report the highest-priority latched event
			if (run_en) begin
				if (rel_key != '0) begin
					r.ev = EV_KEY_RELEASE;
					r.code = CODE_W'(rel_key);
				end else if (press_key != '0) begin
					r.ev = EV_KEY_PRESS;
					r.code = CODE_W'(press_key);
				end else if (left_knob != '0) begin
					r.ev = EV_TURN_LEFT;
					r.code = left_knob;
					r.steps = step_total;
				end else if (right_knob != '0) begin
					r.ev = EV_TURN_RIGHT;
					r.code = right_knob;
					r.steps = step_total;
				end else if (knob_down != '0) begin
					r.ev = EV_KNOB_PRESS;
					r.code = knob_down;
					knob_down = '0;
				end else if (knob_up != '0) begin
					r.ev = EV_KNOB_RELEASE;
					r.code = knob_up;
					knob_up = '0;
				end else if (reset_req) begin
					r.ev = EV_RESET;
					reset_req = 1'b0;
				end
			end
			// key and turn latches always clear on service
			rel_key = '0;
			press_key = '0;
			left_knob = '0;
			right_knob = '0;
			step_total = '0;
		end
		return r;
	endfunction

	function automatic void check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			fail_count++;
		end
	endfunction

	// register writes, result compare, then request prediction
	always @(posedge clk or negedge arst_n) begin
		panel_result_t want;
		if (!arst_n) begin
			run_en = RUNNING_RST;
			debounce = DEBOUNCE_RST;
			rst_code = RST_CODE_RST;
			release_stamp = '0;
			press_stamp = '0;
			rel_key = '0;
			press_key = '0;
			left_knob = '0;
			right_knob = '0;
			knob_down = '0;
			knob_up = '0;
			step_total = '0;
			reset_req = 1'b0;
			pending_results.delete();
			fail_count = 0;
			outstanding = 0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_RUNNING:    run_en = wr_data[0];
					REG_DEBOUNCE:   debounce = wr_data[DEB_W-1:0];
					REG_RESET_CODE: rst_code = wr_data[CMD_W-1:0];
					default:        ;
				endcase
			end
			if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
				if (pending_results.size() == 0) begin
					$error("result with no request waiting");
					fail_count++;
				end else begin
					want = pending_results.pop_front();
					check_field("accepted", 8'(want.accepted), 8'(out_ch.accepted));
					check_field("event_kind", 8'(want.ev), 8'(out_ch.event_kind));
					check_field("event_code", 8'(want.code), 8'(out_ch.event_code));
					check_field("turn_steps", 8'(want.steps), 8'(out_ch.turn_steps));
					check_field("captured_key", 8'(want.captured), 8'(out_ch.captured_key));
				end
			end
			if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
				pending_results.push_back(decode_request(in_ch.kind, in_ch.command_byte,
					in_ch.time_ms));
			outstanding = pending_results.size();
		end
	end

endmodule

// ===== tb/panel_key_encoder_event_latch_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// panel_key_encoder_event_latch_test
// Drives the panel decoder through several register settings: a directed run
// over every command class, debounce edge and service report, then random
// panel traffic built mostly from command bursts closed by a service tick.
// Both channels idle at random; the result side holds off once for a long
// stretch. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module panel_key_encoder_event_latch_test;
	import pkee_pkg::*;

	localparam int unsigned LONG_HOLD_AT     = 200;
	localparam int unsigned LONG_HOLD_CYCLES = 300;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                wr_en;
	logic [WIDX_W-1:0]   wr_index;
	logic [WDATA_W-1:0]  wr_data;
	int                  fail_count;
	int                  outstanding;

	// pacing of each side, and the panel clock in ms
	logic                tx_pace;
	logic                rx_pace;
	logic [TIME_W-1:0]   now_ms;
	int unsigned         cfg_debounce;
	logic [CMD_W-1:0]    cfg_reset_code;

	pkee_in_if  in_ch();
	pkee_out_if out_ch();

	panel_key_encoder_event_latch dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	panel_key_encoder_event_latch_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_ch),
		.out_ch      (out_ch),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always #4 clk = ~clk;

	// run limit
	initial begin
		#5_000_000;
		$display("FAIL panel_key_encoder_event_latch");
		$finish;
	end

	// advance the panel clock: mostly debounce-scale steps, some repeats, some jumps
	function automatic logic [TIME_W-1:0] tick_ms();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 4)
			now_ms = $urandom;
		else if (pick < 10)
			now_ms = now_ms + cfg_debounce + $urandom_range(0, 1);
		else if (pick >= 20)
			now_ms = now_ms + $urandom_range(0, 2 * cfg_debounce + 2);
		return now_ms;
	endfunction

	// command byte from one of the panel's classes
	function automatic logic [CMD_W-1:0] panel_byte();
		case ($urandom_range(0, 9))
			0, 9: return CMD_W'($urandom_range(1, NUM_KEYS - 1));
			1:    return PRESS_BIT | CMD_W'($urandom_range(1, NUM_KEYS - 1));
			2:    return CMD_W'($urandom_range(TURN_LO, TURN_HI));
			3:    return PRESS_BIT | CMD_W'($urandom_range(TURN_LO, TURN_HI));
			4:    return PRESS_BIT | CMD_W'($urandom_range(KNOB_LO, KNOB_HI));
			5:    return CMD_W'($urandom_range(KNOB_LO, KNOB_HI));
			6:    return cfg_reset_code;
			7:    return CMD_W'($urandom);
			default: return '0;
		endcase
	endfunction

	// offer one request and wait for it to be taken
	task automatic send_request(logic kind, logic [CMD_W-1:0] cmd, logic [TIME_W-1:0] t);
		int unsigned gap;
		gap = tx_pace ? $urandom_range(0, 16) : 0;
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.kind <= kind;
		in_ch.command_byte <= cmd;
		in_ch.time_ms <= t;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		@(negedge clk);
	endtask

	// stop offering and let every result come back
	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// write all three registers while the block is idle
	task automatic set_config(logic run, logic [DEB_W-1:0] deb, logic [CMD_W-1:0] code);
		wait_idle();
		wr_en <= 1'b1;
		wr_index <= REG_RUNNING;
		wr_data <= WDATA_W'(run);
		@(negedge clk);
		wr_index <= REG_DEBOUNCE;
		wr_data <= WDATA_W'(deb);
		@(negedge clk);
		wr_index <= REG_RESET_CODE;
		wr_data <= WDATA_W'(code);
		@(negedge clk);
		wr_en <= 1'b0;
		cfg_debounce = deb;
		cfg_reset_code = code;
	endtask

	// command bursts closed by a service tick, with some noise requests
	task automatic random_traffic(int unsigned n);
		int unsigned sent;
		int unsigned burst;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(0, 99) < 20) begin
				send_request(1'($urandom), CMD_W'($urandom), tick_ms());
				sent++;
			end else begin
				burst = $urandom_range(1, 6);
				repeat (burst) begin
					send_request(KIND_COMMAND, panel_byte(), tick_ms());
					sent++;
				end
				send_request(KIND_SERVICE, CMD_W'($urandom), tick_ms());
				sent++;
			end
		end
	endtask

	// result side: random stall per result, one long hold-off
	initial begin
		int unsigned stall;
		int unsigned taken;
		taken = 0;
		out_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = rx_pace ? $urandom_range(0, 16) : 0;
			if (taken == LONG_HOLD_AT)
				stall = LONG_HOLD_CYCLES;
			if (stall != 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (out_ch.valid !== 1'b1);
			taken++;
			@(negedge clk);
		end
	end

	// request side and verdict
	initial begin
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		in_ch.valid = 1'b0;
		in_ch.kind = KIND_COMMAND;
		in_ch.command_byte = '0;
		in_ch.time_ms = '0;
		tx_pace = 1'b1;
		rx_pace = 1'b1;
		now_ms = '0;
		cfg_debounce = DEBOUNCE_RST;
		cfg_reset_code = RST_CODE_RST;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed pass over every class with reset settings
		set_config(RUNNING_RST, DEBOUNCE_RST, RST_CODE_RST);
		send_request(KIND_COMMAND, 8'd0, 32'd0);                     // zero byte
		send_request(KIND_COMMAND, 8'd1, 32'd0);                     // release inside debounce
		send_request(KIND_COMMAND, KEY_LIMIT - 8'd1, 32'd101);
		send_request(KIND_COMMAND, PRESS_BIT | 8'd1, 32'd101);
		send_request(KIND_COMMAND, PRESS_LIMIT - 8'd1, 32'd150);     // press inside debounce
		send_request(KIND_COMMAND, TURN_LO, 32'd150);
		send_request(KIND_COMMAND, TURN_HI | PRESS_BIT, 32'd150);
		send_request(KIND_COMMAND, KNOB_LO | PRESS_BIT, 32'd150);
		send_request(KIND_COMMAND, KNOB_HI | PRESS_BIT, 32'd150);
		send_request(KIND_COMMAND, KNOB_LO, 32'd150);
		send_request(KIND_COMMAND, KNOB_HI, 32'd150);
		send_request(KIND_COMMAND, RST_CODE_RST, 32'd150);
		send_request(KIND_COMMAND, KEY_LIMIT, 32'd150);              // just past the keys
		send_request(KIND_COMMAND, PRESS_BIT, 32'd150);              // bare press bit
		send_request(KIND_SERVICE, 8'd0, 32'd160);
		send_request(KIND_COMMAND, PRESS_BIT | 8'd5, 32'd300);
		send_request(KIND_SERVICE, 8'hff, 32'd300);
		// both turn directions latched together
		send_request(KIND_COMMAND, TURN_LO + 8'd1, 32'd300);
		send_request(KIND_COMMAND, TURN_HI | PRESS_BIT, 32'd300);
		send_request(KIND_COMMAND, TURN_HI, 32'd300);
		repeat (5) send_request(KIND_SERVICE, 8'd0, 32'd300);
		// debounce across the wrap of the ms counter
		send_request(KIND_COMMAND, 8'd5, 32'hffff_ffff);
		send_request(KIND_COMMAND, 8'd6, 32'd50);
		now_ms = 32'd50;
		random_traffic(45);

		// no debounce, free reset code, no idling
		tx_pace = 1'b0;
		rx_pace = 1'b0;
		set_config(1'b1, 16'd0, KEY_LIMIT);
		random_traffic(45);

		// longest debounce, reset code that can never fire
		tx_pace = 1'b1;
		set_config(1'b1, 16'hffff, 8'd0);
		random_traffic(45);

		// not running: only released keys are captured
		tx_pace = 1'b0;
		rx_pace = 1'b1;
		set_config(1'b0, 16'd50, RST_CODE_RST);
		random_traffic(45);

		// reset code shadowed by a key press; step count saturation
		tx_pace = 1'b1;
		set_config(1'b1, 16'd3, PRESS_BIT | 8'd1);
		repeat (258)
			send_request(KIND_COMMAND,
				CMD_W'(($urandom_range(0, 1) ? (TURN_LO | PRESS_BIT) : TURN_LO)
				+ $urandom_range(0, 7)), tick_ms());
		send_request(KIND_SERVICE, 8'd0, tick_ms());
		random_traffic(45);

		// not running with no debounce, reset code shadowed by a turn
		set_config(1'b0, 16'd0, TURN_LO);
		random_traffic(45);

		// back to running with a random reset code
		rx_pace = 1'b0;
		set_config(1'b1, 16'd1000, CMD_W'($urandom));
		random_traffic(45);

		wait_idle();
		if (fail_count == 0)
			$display("PASS panel_key_encoder_event_latch");
		else
			$display("FAIL panel_key_encoder_event_latch");
		$finish;
	end

endmodule
